// ===== hdl/rmf_pkg.sv =====
// rmf_pkg: shared types and constants for the rgb median filter window unit
// no dependencies; imported by rmf_front, rmf_back and the top level
`default_nettype none

package rmf_pkg;

  localparam int CH_W     = 8;
  localparam int PIX_W    = 3 * CH_W;
  localparam int FW_W     = 11;
  localparam int FH_W     = 13;
  localparam int CFG_D_W  = 13;

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_ACCEPT  = 2'b01,
    ST_PRELOAD = 2'b10
  } front_state_t;

  // what the back end does with one fetched window column
  typedef struct packed {
    logic clear;
    logic emit;
    logic last;
  } col_flags_t;

endpackage

`default_nettype wire

// ===== hdl/rmf_ram.sv =====
// rmf_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module rmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/rmf_queue.sv =====
// rmf_queue: short fifo between the front end and the back end
// no dependencies
`default_nettype none

module rmf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int PW  = $clog2(DEPTH),
  localparam int CNW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty,
  output logic                  full,
  output logic      [CNW-1:0]   count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;

  assign empty = (count == '0);
  assign full  = (count == CNW'(DEPTH));
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rmf_front.sv =====
// rmf_front: config registers, position counters, line store banks and column fetch
// depends on rmf_pkg and rmf_ram
`default_nettype none

module rmf_front
  import rmf_pkg::*;
#(
  parameter int WINDOW    = 3,
  parameter int MAX_WIDTH = 1024,
  parameter int QDEPTH    = 8,
  localparam int QCW = $clog2(QDEPTH + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [CFG_D_W-1:0]        cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [PIX_W-1:0]          in_pix,
  input  wire logic                      in_drain,
  input  wire logic [QCW-1:0]            q_count,
  output logic                           push,
  output col_flags_t                     push_flags,
  output logic [WINDOW*PIX_W-1:0]        push_col
);

  localparam int HALF_LO = WINDOW / 2;
  localparam int HALF_HI = WINDOW - 1 - HALF_LO;
  localparam int RING    = WINDOW + 1;
  localparam int BW      = $clog2(RING);
  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int CW0     = $clog2(MAX_WIDTH + 1);
  localparam int CW      = (CW0 > FW_W) ? CW0 : FW_W;
  localparam int RW      = FH_W;
  localparam int PW      = $clog2(HALF_HI + 1);

  function automatic logic [BW-1:0] ring_wrap(input logic [BW+1:0] v);
    logic [BW+1:0] t;
    t = v;
    if (t >= (BW+2)'(2 * RING)) begin
      t = t - (BW+2)'(2 * RING);
    end else if (t >= (BW+2)'(RING)) begin
      t = t - (BW+2)'(RING);
    end
    return t[BW-1:0];
  endfunction

  function automatic logic [BW-1:0] bank_inc(input logic [BW-1:0] b);
    return (b == BW'(RING - 1)) ? '0 : b + 1'b1;
  endfunction

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [CW-1:0]   in_col, out_col;
  logic [RW-1:0]   in_row, out_row;
  logic [BW-1:0]   in_bank, out_bank;
  front_state_t    state;
  logic [PW-1:0]   pre_cnt;
  logic [BW-1:0]   ctx_sel [WINDOW];
  logic [WINDOW-1:0] ctx_mask;
  logic            ctx_last;

  logic            s1_valid;
  col_flags_t      s1_flags;
  logic [BW-1:0]   s1_sel [WINDOW];
  logic [WINDOW-1:0] s1_mask;
  logic [WINDOW-1:0] s1_hit;
  logic            s1_col_zero;
  logic [PIX_W-1:0] s1_wdata;

  logic [CW-1:0]   w_eff;
  logic [RW-1:0]   h_eff;
  logic            in_fire, restart, we, dec, space, issue, last_b, col_zero;
  logic [CW-1:0]   ic_b, ic_n, oc_b, oc_n;
  logic [RW-1:0]   ir_b, ir_n, or_b, or_n;
  logic [BW-1:0]   ib_b, ib_n, ob_b, ob_n;
  logic [RW:0]     need_r;
  logic [CW:0]     need_c;
  logic            emit_rdy;
  logic [WINDOW-1:0] mask_now, mask_f, hit;
  logic [BW-1:0]   sel_now [WINDOW];
  logic [BW-1:0]   sel_f [WINDOW];
  logic [CW:0]     fc;
  logic [AW-1:0]   raddr;
  col_flags_t      flags_f;
  logic [PIX_W-1:0] bank_rd [RING];

  always_comb begin
    if (frame_width == '0) begin
      w_eff = CW'(1);
    end else if (CW'(frame_width) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width);
    end
    h_eff = (frame_height == '0) ? RW'(1) : frame_height;
  end

  assign space    = ({1'b0, q_count} + (QCW+1)'(s1_valid)) < (QCW+1)'(QDEPTH);
  assign in_ready = (state == ST_ACCEPT) && space;
  assign in_fire  = in_valid && in_ready;

  // input position update and result readiness, as seen after this beat
  always_comb begin
    logic [RW:0] t;
    restart = !in_drain && (in_row >= h_eff);
    ic_b = restart ? '0 : in_col;
    ir_b = restart ? '0 : in_row;
    ib_b = restart ? '0 : in_bank;
    oc_b = restart ? '0 : out_col;
    or_b = restart ? '0 : out_row;
    ob_b = restart ? '0 : out_bank;
    we   = in_fire && !in_drain;

    ic_n = ic_b;
    ir_n = ir_b;
    ib_n = ib_b;
    if (!in_drain) begin
      if (ic_b + 1'b1 >= w_eff) begin
        ic_n = '0;
        ir_n = ir_b + 1'b1;
        ib_n = bank_inc(ib_b);
      end else begin
        ic_n = ic_b + 1'b1;
      end
    end

    need_r = {1'b0, or_b} + (RW+1)'(HALF_HI);
    if (need_r > {1'b0, h_eff} - 1'b1) begin
      need_r = {1'b0, h_eff} - 1'b1;
    end
    need_c = {1'b0, oc_b} + (CW+1)'(HALF_HI);
    if (need_c > {1'b0, w_eff} - 1'b1) begin
      need_c = {1'b0, w_eff} - 1'b1;
    end
    emit_rdy = (or_b < h_eff) &&
               (({1'b0, ir_n} > need_r) ||
                (({1'b0, ir_n} == need_r) && ({1'b0, ic_n} > need_c)));
    dec = in_fire && emit_rdy;

    oc_n = oc_b;
    or_n = or_b;
    ob_n = ob_b;
    if (dec) begin
      if (oc_b + 1'b1 >= w_eff) begin
        oc_n = '0;
        or_n = or_b + 1'b1;
        ob_n = bank_inc(ob_b);
      end else begin
        oc_n = oc_b + 1'b1;
      end
    end
    last_b = (or_b == h_eff - 1'b1) && (oc_b == w_eff - 1'b1);

    for (int i = 0; i < WINDOW; i++) begin
      t = {1'b0, or_b} + (RW+1)'(i);
      mask_now[i] = (t >= (RW+1)'(HALF_LO)) && (t < {1'b0, h_eff} + (RW+1)'(HALF_LO));
      sel_now[i]  = ring_wrap({2'b00, ob_b} + (BW+2)'(RING - HALF_LO + i));
    end
  end

  // column fetch: one column per cycle while the queue has space, a row start preloads the columns right of it
  always_comb begin
    if (state == ST_PRELOAD) begin
      issue         = space;
      fc            = (CW+1)'(pre_cnt);
      flags_f.clear = 1'b0;
      flags_f.emit  = (pre_cnt == PW'(HALF_HI));
      flags_f.last  = ctx_last;
      mask_f        = ctx_mask;
      sel_f         = ctx_sel;
    end else begin
      issue         = dec;
      fc            = (oc_b == '0) ? '0 : {1'b0, oc_b} + (CW+1)'(HALF_HI);
      flags_f.clear = (oc_b == '0);
      flags_f.emit  = (oc_b != '0);
      flags_f.last  = last_b;
      mask_f        = mask_now;
      sel_f         = sel_now;
    end
    col_zero = (fc >= {1'b0, w_eff});
    raddr    = fc[AW-1:0];
    for (int i = 0; i < WINDOW; i++) begin
      hit[i] = we && (ib_b == sel_f[i]) && ({1'b0, ic_b} == fc);
    end
  end

  for (genvar b = 0; b < RING; b++) begin : g_bank
    rmf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (we && (ib_b == BW'(b))),
      .waddr (ic_b[AW-1:0]),
      .wdata (in_pix),
      .raddr (raddr),
      .rdata (bank_rd[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
      in_col       <= '0;
      in_row       <= '0;
      in_bank      <= '0;
      out_col      <= '0;
      out_row      <= '0;
      out_bank     <= '0;
      state        <= ST_ACCEPT;
      pre_cnt      <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          frame_width <= cfg_data[FW_W-1:0];
        end else begin
          frame_height <= cfg_data[FH_W-1:0];
        end
        in_col   <= '0;
        in_row   <= '0;
        in_bank  <= '0;
        out_col  <= '0;
        out_row  <= '0;
        out_bank <= '0;
        state    <= ST_ACCEPT;
      end else begin
        if (in_fire) begin
          in_col   <= ic_n;
          in_row   <= ir_n;
          in_bank  <= ib_n;
          out_col  <= oc_n;
          out_row  <= or_n;
          out_bank <= ob_n;
        end
        case (state)
          ST_ACCEPT: begin
            if (dec && (oc_b == '0)) begin
              state   <= ST_PRELOAD;
              pre_cnt <= PW'(1);
            end
          end
          ST_PRELOAD: begin
            if (space) begin
              if (pre_cnt == PW'(HALF_HI)) begin
                state <= ST_ACCEPT;
              end else begin
                pre_cnt <= pre_cnt + 1'b1;
              end
            end
          end
          default: state <= ST_ACCEPT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ACCEPT) begin
      ctx_sel  <= sel_now;
      ctx_mask <= mask_now;
      ctx_last <= last_b;
    end
    s1_flags    <= flags_f;
    s1_sel      <= sel_f;
    s1_mask     <= mask_f;
    s1_hit      <= hit;
    s1_col_zero <= col_zero;
    s1_wdata    <= in_pix;
  end

  assign push       = s1_valid;
  assign push_flags = s1_flags;

  // rows outside the frame and columns past the right edge read as zero
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      if (!s1_mask[i] || s1_col_zero) begin
        push_col[i*PIX_W +: PIX_W] = '0;
      end else if (s1_hit[i]) begin
        push_col[i*PIX_W +: PIX_W] = s1_wdata;
      end else begin
        push_col[i*PIX_W +: PIX_W] = bank_rd[s1_sel[i]];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rmf_back.sv =====
// rmf_back: sliding window registers and pipelined rank-select median per channel
// depends on rmf_pkg
`default_nettype none

module rmf_back
  import rmf_pkg::*;
#(
  parameter int WINDOW = 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_empty,
  output logic                         pop,
  input  wire col_flags_t              q_flags,
  input  wire logic [WINDOW*PIX_W-1:0] q_col,
  output logic                         m_valid,
  input  wire logic                    m_ready,
  output logic [PIX_W-1:0]             m_median,
  output logic                         m_last
);

  localparam int TAPS = WINDOW * WINDOW;
  localparam int RKW  = $clog2(TAPS);
  localparam int MID  = TAPS / 2;

  logic [PIX_W-1:0] win    [WINDOW][WINDOW];
  logic [PIX_W-1:0] win_nx [WINDOW][WINDOW];

  logic            adv;
  logic            sa_valid, sa_last, sb_valid, sb_last;
  logic [CH_W-1:0] sa_val [3][TAPS];
  logic [CH_W-1:0] sb_val [3][TAPS];
  logic [TAPS-1:0] lt_nx  [3][TAPS];
  logic [TAPS-1:0] sb_lt  [3][TAPS];
  logic [CH_W-1:0] med_nx [3];

  assign adv = !m_valid || m_ready;
  assign pop = adv && !q_empty;

  // shift one column in from the right, a row start clears the old columns
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      for (int r = 0; r < WINDOW; r++) begin
        if (k == WINDOW - 1) begin
          win_nx[k][r] = q_col[r*PIX_W +: PIX_W];
        end else if (q_flags.clear) begin
          win_nx[k][r] = '0;
        end else begin
          win_nx[k][r] = win[(k == WINDOW - 1) ? k : k + 1][r];
        end
      end
    end
  end

  // ties broken by tap index so ranks form a permutation
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < TAPS; i++) begin
        for (int j = 0; j < TAPS; j++) begin
          lt_nx[c][i][j] = (j != i) &&
                           ((sa_val[c][j] < sa_val[c][i]) ||
                            ((sa_val[c][j] == sa_val[c][i]) && (j < i)));
        end
      end
    end
  end

  always_comb begin
    logic [RKW-1:0] rank;
    for (int c = 0; c < 3; c++) begin
      med_nx[c] = '0;
      for (int i = 0; i < TAPS; i++) begin
        rank = '0;
        for (int j = 0; j < TAPS; j++) begin
          rank = rank + RKW'(sb_lt[c][i][j]);
        end
        if (rank == RKW'(MID)) begin
          med_nx[c] = med_nx[c] | sb_val[c][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
      sb_valid <= 1'b0;
      m_valid  <= 1'b0;
      for (int k = 0; k < WINDOW; k++) begin
        for (int r = 0; r < WINDOW; r++) begin
          win[k][r] <= '0;
        end
      end
    end else if (adv) begin
      sa_valid <= pop && q_flags.emit;
      sb_valid <= sa_valid;
      m_valid  <= sb_valid;
      if (pop) begin
        win <= win_nx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_last <= q_flags.last;
      for (int k = 0; k < WINDOW; k++) begin
        for (int r = 0; r < WINDOW; r++) begin
          for (int c = 0; c < 3; c++) begin
            sa_val[c][k*WINDOW + r] <= win_nx[k][r][c*CH_W +: CH_W];
          end
        end
      end
      sb_last  <= sa_last;
      sb_val   <= sa_val;
      sb_lt    <= lt_nx;
      m_last   <= sb_last;
      m_median <= {med_nx[2], med_nx[1], med_nx[0]};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rgb_median_filter_window_unit.sv =====
// rgb_median_filter_window_unit: top level of the per-channel window median filter
// depends on rmf_pkg, rmf_front, rmf_queue, rmf_back
//
//  channel | direction | signals                          | carries
//  --------+-----------+----------------------------------+------------------------------
//  cfg     | in        | cfg_valid/ready, index, data      | frame_width, frame_height
//  s_axis  | in        | s_tvalid/tready, tdata, tuser     | pixel beat or drain beat
//  m_axis  | out       | m_tvalid/tready, tdata, tlast     | window median, frame end mark
//
// one beat per cycle while the queue has room; each row's first result waits while the
// front end fetches the columns to its right from the line store banks (one column per
// cycle over the WINDOW+1 banks, space allowing). results pass the fetch register, column
// queue and back end sa, sb and output registers. reset is synchronous, no clearing pass
// runs. either side may stall alone: the column queue and output register decouple them.
`default_nettype none

module rgb_median_filter_window_unit
  import rmf_pkg::*;
#(
  parameter int WINDOW    = 3,
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [CFG_D_W-1:0] cfg_data,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [PIX_W-1:0]   s_tdata,   // chan_a, chan_b, chan_c
  input  wire logic               s_tuser,   // drain
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [PIX_W-1:0]        m_tdata,   // median_a, median_b, median_c
  output logic                    m_tlast
);

  localparam int QDEPTH = 8;
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam int QW     = WINDOW * PIX_W + $bits(col_flags_t);

  logic                    push, pop, q_empty, q_full;
  logic [QCW-1:0]          q_count;
  col_flags_t              push_flags, q_flags;
  logic [WINDOW*PIX_W-1:0] push_col, q_col;
  logic [QW-1:0]           q_dout;

  assign cfg_ready = 1'b1;

  rmf_front #(
    .WINDOW    (WINDOW),
    .MAX_WIDTH (MAX_WIDTH),
    .QDEPTH    (QDEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_pix     (s_tdata),
    .in_drain   (s_tuser),
    .q_count    (q_count),
    .push       (push),
    .push_flags (push_flags),
    .push_col   (push_col)
  );

  rmf_queue #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({push_flags, push_col}),
    .pop   (pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full),
    .count (q_count)
  );

  assign q_flags = q_dout[QW-1 -: $bits(col_flags_t)];
  assign q_col   = q_dout[WINDOW*PIX_W-1:0];

  rmf_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .pop      (pop),
    .q_flags  (q_flags),
    .q_col    (q_col),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_median (m_tdata),
    .m_last   (m_tlast)
  );

  // front end credit check must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("column queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("column queue underflow");

  a_reset_quiet: assert property (@(posedge clk) ($past(rst) && !rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCW'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire
